[rtl/sccc_pkg.sv]
// Shared types, character codes and byte-class functions for the completion context classifier.
package sccc_pkg;

  localparam int MAX_LINE = 1024;
  localparam int POS_W    = $clog2(MAX_LINE + 1);
  localparam int IDX_W    = POS_W + 1;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_US     = 8'h5F;
  localparam logic [7:0] CH_PIPE   = 8'h7C;

  typedef enum logic [1:0] {
    PH_NONE  = 2'd0,
    PH_NAME  = 2'd1,
    PH_AFTER = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    CTX_COMMAND    = 3'd0,
    CTX_ARGUMENT   = 3'd1,
    CTX_VARIABLE   = 3'd2,
    CTX_ASSIGNMENT = 3'd3,
    CTX_REDIRECT   = 3'd4
  } ctx_t;

  typedef struct packed {
    phase_t             phase;
    logic [POS_W-1:0]   start;
    logic [POS_W-1:0]   length;
    logic [POS_W-1:0]   count;
    logic               in_word;
  } cmd_track_t;

  // Line state as it stands after the current byte has been taken.
  typedef struct packed {
    logic [POS_W-1:0]   position;
    logic [POS_W-1:0]   tok_begin;
    logic [7:0]         first_byte;
    logic               quote_open;
    logic               assign_snap;
    logic               ns_seen;
    logic [7:0]         ns_byte;
    cmd_track_t         cmd;
    logic               overflow;
  } line_view_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_alnum_us(input logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
           ((c >= 8'h61) && (c <= 8'h7A)) || (c == CH_US);
  endfunction

  function automatic logic is_sep(input logic [7:0] c);
    return (c == CH_PIPE) || (c == CH_SEMI) || (c == CH_AMP);
  endfunction

  function automatic logic is_boundary(input logic [7:0] c);
    return is_ws(c) || is_sep(c) || (c == CH_LPAREN) || (c == CH_RPAREN) ||
           (c == CH_LT) || (c == CH_GT) || (c == CH_NUL);
  endfunction

endpackage

[rtl/sccc_tracker.sv]
// Running line state: quotes, word start, assignment, command tracking and snapshots.
module sccc_tracker import sccc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        take,
  input  logic        clear,
  input  logic [7:0]  char_code,
  output line_view_t  view
);

  logic [POS_W-1:0] position, position_next;
  logic             single_quote_open, single_quote_open_next;
  logic             double_quote_open, double_quote_open_next;
  logic [POS_W-1:0] tok_begin, tok_begin_next;
  logic [7:0]       first_byte, first_byte_next;
  logic [7:0]       previous_byte, previous_byte_next;
  logic             assign_running, assign_running_next;
  logic             assign_snapshot, assign_snapshot_next;
  logic [7:0]       last_nonspace, last_nonspace_next;
  logic             seen_nonspace, seen_nonspace_next;
  logic [8:0]       nonspace_snapshot, nonspace_snapshot_next;
  cmd_track_t       cmd, cmd_next;
  cmd_track_t       cmd_snapshot, cmd_snapshot_next;
  logic             overflow, overflow_next;

  always_comb begin
    position_next          = position;
    single_quote_open_next = single_quote_open;
    double_quote_open_next = double_quote_open;
    tok_begin_next         = tok_begin;
    first_byte_next        = first_byte;
    previous_byte_next     = previous_byte;
    assign_running_next    = assign_running;
    assign_snapshot_next   = assign_snapshot;
    last_nonspace_next     = last_nonspace;
    seen_nonspace_next     = seen_nonspace;
    nonspace_snapshot_next = nonspace_snapshot;
    cmd_next               = cmd;
    cmd_snapshot_next      = cmd_snapshot;
    overflow_next          = overflow;

    if (take) begin
      if (position >= POS_W'(MAX_LINE)) begin
        overflow_next = 1'b1;
      end else begin
        if (char_code == CH_SQUOTE && !double_quote_open) begin
          single_quote_open_next = !single_quote_open;
        end else if (char_code == CH_DQUOTE && !single_quote_open) begin
          double_quote_open_next = !double_quote_open;
        end

        if (is_ws(char_code) || char_code == CH_SEMI || char_code == CH_PIPE) begin
          assign_running_next = 1'b0;
        end else if (char_code == CH_EQ && position != '0 && is_alnum_us(previous_byte)) begin
          assign_running_next = 1'b1;
        end

        if (!is_ws(char_code)) begin
          last_nonspace_next = char_code;
          seen_nonspace_next = 1'b1;
        end

        if (is_sep(char_code)) begin
          cmd_next = '0;
        end else begin
          case (cmd.phase)
            PH_NONE: begin
              if (!is_ws(char_code)) begin
                cmd_next.phase  = PH_NAME;
                cmd_next.start  = position;
                cmd_next.length = POS_W'(1);
              end
            end
            PH_NAME: begin
              if (is_ws(char_code)) begin
                cmd_next.phase   = PH_AFTER;
                cmd_next.in_word = 1'b0;
                cmd_next.count   = '0;
              end else begin
                cmd_next.length = cmd.length + POS_W'(1);
              end
            end
            default: begin
              if (is_ws(char_code)) begin
                cmd_next.in_word = 1'b0;
              end else if (!cmd.in_word) begin
                cmd_next.count   = cmd.count + POS_W'(1);
                cmd_next.in_word = 1'b1;
              end
            end
          endcase
        end

        if (position == tok_begin && !is_boundary(char_code)) begin
          first_byte_next = char_code;
        end

        previous_byte_next = char_code;
        position_next      = position + POS_W'(1);

        // A boundary byte closes the word: freeze the running flags for the next one.
        if (is_boundary(char_code)) begin
          tok_begin_next         = position_next;
          assign_snapshot_next   = assign_running_next;
          nonspace_snapshot_next = {seen_nonspace_next, last_nonspace_next};
          cmd_snapshot_next      = cmd_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      position          <= '0;
      single_quote_open <= 1'b0;
      double_quote_open <= 1'b0;
      tok_begin         <= '0;
      first_byte        <= '0;
      previous_byte     <= '0;
      assign_running    <= 1'b0;
      assign_snapshot   <= 1'b0;
      last_nonspace     <= '0;
      seen_nonspace     <= 1'b0;
      nonspace_snapshot <= '0;
      cmd               <= '0;
      cmd_snapshot      <= '0;
      overflow          <= 1'b0;
    end else begin
      position          <= position_next;
      single_quote_open <= single_quote_open_next;
      double_quote_open <= double_quote_open_next;
      tok_begin         <= tok_begin_next;
      first_byte        <= first_byte_next;
      previous_byte     <= previous_byte_next;
      assign_running    <= assign_running_next;
      assign_snapshot   <= assign_snapshot_next;
      last_nonspace     <= last_nonspace_next;
      seen_nonspace     <= seen_nonspace_next;
      nonspace_snapshot <= nonspace_snapshot_next;
      cmd               <= cmd_next;
      cmd_snapshot      <= cmd_snapshot_next;
      overflow          <= overflow_next;
    end
  end

  always_comb begin
    view.position    = position_next;
    view.tok_begin   = tok_begin_next;
    view.first_byte  = first_byte_next;
    view.quote_open  = single_quote_open_next || double_quote_open_next;
    view.assign_snap = assign_snapshot_next;
    view.ns_seen     = nonspace_snapshot_next[8];
    view.ns_byte     = nonspace_snapshot_next[7:0];
    view.cmd         = cmd_snapshot_next;
    view.overflow    = overflow_next;
  end

endmodule

[rtl/sccc_classify.sv]
// Context decision and result fields from the line state at the cursor.
module sccc_classify import sccc_pkg::*; (
  input  line_view_t              view,
  output ctx_t                    ctx,
  output logic                    redirect,
  output logic [POS_W-1:0]        name_start,
  output logic [POS_W-1:0]        cmd_length,
  output logic signed [IDX_W-1:0] arg_pos
);

  logic command_pos;

  always_comb begin
    redirect    = view.ns_seen && (view.ns_byte == CH_LT || view.ns_byte == CH_GT);
    command_pos = !view.ns_seen || is_sep(view.ns_byte);

    if (view.position > view.tok_begin && view.first_byte == CH_DOLLAR) begin
      ctx = CTX_VARIABLE;
    end else if (view.assign_snap) begin
      ctx = CTX_ASSIGNMENT;
    end else if (redirect) begin
      ctx = CTX_REDIRECT;
    end else if (command_pos) begin
      ctx = CTX_COMMAND;
    end else begin
      ctx = CTX_ARGUMENT;
    end

    name_start = '0;
    cmd_length = '0;
    arg_pos    = '1;
    if (ctx == CTX_ARGUMENT && view.cmd.phase != PH_NONE) begin
      name_start = view.cmd.start;
      cmd_length = view.cmd.length;
      arg_pos    = (view.cmd.phase == PH_AFTER) ? $signed({1'b0, view.cmd.count}) : '0;
    end
  end

endmodule

[rtl/shell_completion_context_classifier_unit.sv]
// Top level of the shell completion context classifier: input register, tracker, result register.
//
// The block reads a command line one byte per item transfer on the item channel
// (item_valid, item_stall, char_code, is_last, no_char), from the start of the line up to
// the cursor. An item with no_char set carries no byte. The item with is_last set ends the
// line, and exactly one result transfer follows it on the result channel (result_valid,
// result_stall and the result fields). Items that are not last give no result.
// Each accepted item lands in an input register. From there the tracker updates the line
// state and, for a last item, the classifier's answer is loaded into the result register.
// The block takes one item every cycle. Only a last item can be held up: it waits in the
// input register while the result register holds an untaken result, and the item channel
// then stalls. Results are held stable while result_stall is high.
// After a result is produced, all line state returns to its reset values for the next line.
// Bytes arriving once the line holds MAX_LINE bytes are dropped and the overflow flag is set.
// Synchronous reset clears the line state and both valid flags; no result is offered after it.
module shell_completion_context_classifier_unit import sccc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     item_valid,
  output logic                     item_stall,
  input  logic [7:0]               char_code,
  input  logic                     is_last,
  input  logic                     no_char,
  output logic                     result_valid,
  input  logic                     result_stall,
  output logic [2:0]               context_type,
  output logic [POS_W-1:0]         tok_begin,
  output logic [POS_W-1:0]         tok_end,
  output logic                     quote_flag,
  output logic                     redir_flag,
  output logic                     assign_flag,
  output logic [POS_W-1:0]         command_start,
  output logic [POS_W-1:0]         command_length,
  output logic signed [IDX_W-1:0]  arg_number,
  output logic                     overflow
);

  logic                     hold_valid;
  logic [7:0]               hold_char;
  logic                     hold_last;
  logic                     hold_none;
  logic                     advance;
  logic                     out_free;
  logic                     load_result;
  line_view_t               view;
  ctx_t                     ctx;
  logic                     redirect;
  logic [POS_W-1:0]         name_start;
  logic [POS_W-1:0]         cmd_length;
  logic signed [IDX_W-1:0]  arg_pos;

  // The held item moves on unless it is a last item and the result register holds a stalled result.
  assign out_free    = !result_valid || !result_stall;
  assign advance     = hold_valid && (!hold_last || out_free);
  assign load_result = advance && hold_last;
  assign item_stall  = hold_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (item_valid && !item_stall) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      hold_char <= char_code;
      hold_last <= is_last;
      hold_none <= no_char;
    end
  end

  sccc_tracker u_tracker (
    .clk       (clk),
    .rst       (rst),
    .take      (advance && !hold_none),
    .clear     (load_result),
    .char_code (hold_char),
    .view      (view)
  );

  sccc_classify u_classify (
    .view       (view),
    .ctx        (ctx),
    .redirect   (redirect),
    .name_start (name_start),
    .cmd_length (cmd_length),
    .arg_pos    (arg_pos)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_result) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      context_type   <= ctx;
      tok_begin      <= view.tok_begin;
      tok_end        <= view.position;
      quote_flag     <= view.quote_open;
      redir_flag     <= redirect;
      assign_flag    <= view.assign_snap;
      command_start  <= name_start;
      command_length <= cmd_length;
      arg_number     <= arg_pos;
      overflow       <= view.overflow;
    end
  end

endmodule
